@@ hw/rtl/ybc_pkg.sv @@
// types, coefficients and widths shared by the yuv to bgr pipeline stages
`default_nettype none

package ybc_pkg;

    localparam int PIX_W   = 8;
    localparam int CHR_W   = PIX_W + 1;
    localparam int COEF_W  = 26;
    localparam int PROD_W  = COEF_W + CHR_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int FRAC_LIM  = 8;
    localparam int FRAC_FULL = 24;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FULL_RANGE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_USE_BT709   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SWAP_CHROMA = 2'd2;

    // limited range, scale 256
    localparam logic signed [COEF_W-1:0] LIM_KY      = 26'sd298;
    localparam logic signed [COEF_W-1:0] LIM601_KR   = 26'sd409;
    localparam logic signed [COEF_W-1:0] LIM601_KGB  = 26'sd100;
    localparam logic signed [COEF_W-1:0] LIM601_KGR  = 26'sd208;
    localparam logic signed [COEF_W-1:0] LIM601_KB   = 26'sd516;
    localparam logic signed [COEF_W-1:0] LIM709_KR   = 26'sd459;
    localparam logic signed [COEF_W-1:0] LIM709_KGB  = 26'sd55;
    localparam logic signed [COEF_W-1:0] LIM709_KGR  = 26'sd136;
    localparam logic signed [COEF_W-1:0] LIM709_KB   = 26'sd541;

    // full range, q2.24
    localparam logic signed [COEF_W-1:0] FULL_KY     = 26'sd16777216;
    localparam logic signed [COEF_W-1:0] FULL601_KR  = 26'sd23521657;
    localparam logic signed [COEF_W-1:0] FULL601_KGB = 26'sd5773644;
    localparam logic signed [COEF_W-1:0] FULL601_KGR = 26'sd11981214;
    localparam logic signed [COEF_W-1:0] FULL601_KB  = 26'sd29729227;
    localparam logic signed [COEF_W-1:0] FULL709_KR  = 26'sd26420760;
    localparam logic signed [COEF_W-1:0] FULL709_KGB = 26'sd3142775;
    localparam logic signed [COEF_W-1:0] FULL709_KGR = 26'sd7853817;
    localparam logic signed [COEF_W-1:0] FULL709_KB  = 26'sd31131802;

    localparam logic signed [ACC_W-1:0] LIM_BIAS   = ACC_W'(128);
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_FULL - 1);

    typedef struct packed {
        logic full_range;
        logic use_bt709;
        logic swap_chroma;
    } cfg_t;

    typedef struct packed {
        logic                     full_range;
        logic signed [COEF_W-1:0] k_y;
        logic signed [COEF_W-1:0] k_r;
        logic signed [COEF_W-1:0] k_gb;
        logic signed [COEF_W-1:0] k_gr;
        logic signed [COEF_W-1:0] k_b;
        logic signed [CHR_W-1:0]  c_y;
        logic signed [CHR_W-1:0]  cb;
        logic signed [CHR_W-1:0]  cr;
    } sel_t;

    typedef struct packed {
        logic                     full_range;
        logic signed [PROD_W-1:0] p_y;
        logic signed [PROD_W-1:0] p_r;
        logic signed [PROD_W-1:0] p_gb;
        logic signed [PROD_W-1:0] p_gr;
        logic signed [PROD_W-1:0] p_b;
    } prod_t;

    typedef struct packed {
        logic                    full_range;
        logic signed [ACC_W-1:0] a_r;
        logic signed [ACC_W-1:0] a_g;
        logic signed [ACC_W-1:0] a_b;
    } acc_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } pix_t;

endpackage

`default_nettype wire

@@ hw/rtl/ybc_select.sv @@
// stage one: chroma order, offsets and coefficient set for each pixel
`default_nettype none

module ybc_select (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              in_valid,
    output logic                             in_ready,
    input  wire  [ybc_pkg::PIX_W-1:0]        luma,
    input  wire  [ybc_pkg::PIX_W-1:0]        first_chroma,
    input  wire  [ybc_pkg::PIX_W-1:0]        second_chroma,
    input  ybc_pkg::cfg_t                    cfg,
    output logic                             out_valid,
    input  wire                              out_ready,
    output ybc_pkg::sel_t                    out_data
);
    import ybc_pkg::*;

    logic valid_reg;
    sel_t data_reg;
    sel_t data_next;
    logic signed [CHR_W-1:0] first_c;
    logic signed [CHR_W-1:0] second_c;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        first_c  = $signed({1'b0, first_chroma} - CHR_W'(128));
        second_c = $signed({1'b0, second_chroma} - CHR_W'(128));
        data_next.full_range = cfg.full_range;
        data_next.cb = cfg.swap_chroma ? second_c : first_c;
        data_next.cr = cfg.swap_chroma ? first_c : second_c;
        if (cfg.full_range) begin
            data_next.c_y = $signed({1'b0, luma});
            data_next.k_y = FULL_KY;
            if (cfg.use_bt709) begin
                data_next.k_r  = FULL709_KR;
                data_next.k_gb = FULL709_KGB;
                data_next.k_gr = FULL709_KGR;
                data_next.k_b  = FULL709_KB;
            end else begin
                data_next.k_r  = FULL601_KR;
                data_next.k_gb = FULL601_KGB;
                data_next.k_gr = FULL601_KGR;
                data_next.k_b  = FULL601_KB;
            end
        end else begin
            // limited range works on y minus the black level
            data_next.c_y = $signed({1'b0, luma} - CHR_W'(16));
            data_next.k_y = LIM_KY;
            if (cfg.use_bt709) begin
                data_next.k_r  = LIM709_KR;
                data_next.k_gb = LIM709_KGB;
                data_next.k_gr = LIM709_KGR;
                data_next.k_b  = LIM709_KB;
            end else begin
                data_next.k_r  = LIM601_KR;
                data_next.k_gb = LIM601_KGB;
                data_next.k_gr = LIM601_KGR;
                data_next.k_b  = LIM601_KB;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/ybc_mult.sv @@
// stage two: the five coefficient products
`default_nettype none

module ybc_mult (
    input  wire            aclk,
    input  wire            aresetn,
    input  wire            in_valid,
    output logic           in_ready,
    input  ybc_pkg::sel_t  in_data,
    output logic           out_valid,
    input  wire            out_ready,
    output ybc_pkg::prod_t out_data
);
    import ybc_pkg::*;

    logic  valid_reg;
    prod_t data_reg;
    prod_t data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        data_next.full_range = in_data.full_range;
        data_next.p_y  = $signed(in_data.k_y)  * $signed(in_data.c_y);
        data_next.p_r  = $signed(in_data.k_r)  * $signed(in_data.cr);
        data_next.p_gb = $signed(in_data.k_gb) * $signed(in_data.cb);
        data_next.p_gr = $signed(in_data.k_gr) * $signed(in_data.cr);
        data_next.p_b  = $signed(in_data.k_b)  * $signed(in_data.cb);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/ybc_sum.sv @@
// stage three: per-component sums with the limited range bias
`default_nettype none

module ybc_sum (
    input  wire            aclk,
    input  wire            aresetn,
    input  wire            in_valid,
    output logic           in_ready,
    input  ybc_pkg::prod_t in_data,
    output logic           out_valid,
    input  wire            out_ready,
    output ybc_pkg::acc_t  out_data
);
    import ybc_pkg::*;

    logic valid_reg;
    acc_t data_reg;
    acc_t data_next;
    logic signed [ACC_W-1:0] base;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        base = ACC_W'($signed(in_data.p_y)) + (in_data.full_range ? '0 : LIM_BIAS);
        data_next.full_range = in_data.full_range;
        data_next.a_r = base + ACC_W'($signed(in_data.p_r));
        data_next.a_g = base - ACC_W'($signed(in_data.p_gb)) - ACC_W'($signed(in_data.p_gr));
        data_next.a_b = base + ACC_W'($signed(in_data.p_b));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/ybc_clamp.sv @@
// stage four: scale down, round, clamp to a byte; holds the output register
`default_nettype none

module ybc_clamp (
    input  wire            aclk,
    input  wire            aresetn,
    input  wire            in_valid,
    output logic           in_ready,
    input  ybc_pkg::acc_t  in_data,
    output logic           out_valid,
    input  wire            out_ready,
    output ybc_pkg::pix_t  out_data
);
    import ybc_pkg::*;

    logic valid_reg;
    pix_t data_reg;
    pix_t data_next;

    function automatic logic [PIX_W-1:0] to_byte(input logic signed [ACC_W-1:0] v,
                                                 input logic full);
        logic signed [ACC_W-1:0] adj;
        logic signed [ACC_W-1:0] q;
        logic [PIX_W-1:0]        res;
        adj = v;
        if (full) begin
            // half away from zero: negative sums take one less than half
            adj = v + ROUND_HALF - {{(ACC_W-1){1'b0}}, v[ACC_W-1]};
            q   = adj >>> FRAC_FULL;
        end else begin
            q = v >>> FRAC_LIM;
        end
        if (q[ACC_W-1]) begin
            res = '0;
        end else if (|q[ACC_W-2:PIX_W]) begin
            res = '1;
        end else begin
            res = q[PIX_W-1:0];
        end
        return res;
    endfunction

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        data_next.red   = to_byte(in_data.a_r, in_data.full_range);
        data_next.green = to_byte(in_data.a_g, in_data.full_range);
        data_next.blue  = to_byte(in_data.a_b, in_data.full_range);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/yuv_to_bgr_pixel_convert.sv @@
// top level of the per-pixel ycbcr to bgr converter
//
//   channel  ports        beat contents
//   input    s_t*         luma, first_chroma, second_chroma
//   output   m_t*         blue, green, red
//   config   cfg_wr_*     full_range, use_bt709, swap_chroma by index
//
// one pixel per cycle sustained while m_tready is high; a pixel accepted at the input
// passes the select, multiply, sum and clamp registers in that order before it shows
// on m_tvalid, from where it leaves when m_tready is high.
// aresetn is synchronous; it clears the config registers and every stage valid.
// each stage holds its beat while the next one is full and held itself, so a stall on
// m_tready backs up through the full stages and bubbles are squeezed out.
`default_nettype none

module yuv_to_bgr_pixel_convert (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire  [23:0]                       s_tdata,   // luma, first_chroma, second_chroma
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [23:0]                       m_tdata,   // blue, green, red
    input  wire                               cfg_wr_en,
    input  wire  [ybc_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  wire                               cfg_wr_data
);
    import ybc_pkg::*;

    cfg_t  cfg_reg;
    sel_t  sel_data;
    prod_t prod_data;
    acc_t  acc_data;
    pix_t  pix_data;
    logic  sel_valid, sel_ready;
    logic  prod_valid, prod_ready;
    logic  acc_valid, acc_ready;
    logic [2:0] occ_reg;
    logic [2:0] occ_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_FULL_RANGE:  cfg_reg.full_range  <= cfg_wr_data;
                REG_USE_BT709:   cfg_reg.use_bt709   <= cfg_wr_data;
                REG_SWAP_CHROMA: cfg_reg.swap_chroma <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    ybc_select u_select (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .luma          (s_tdata[7:0]),
        .first_chroma  (s_tdata[15:8]),
        .second_chroma (s_tdata[23:16]),
        .cfg           (cfg_reg),
        .out_valid     (sel_valid),
        .out_ready     (sel_ready),
        .out_data      (sel_data)
    );

    ybc_mult u_mult (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sel_valid),
        .in_ready  (sel_ready),
        .in_data   (sel_data),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_data  (prod_data)
    );

    ybc_sum u_sum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_data   (prod_data),
        .out_valid (acc_valid),
        .out_ready (acc_ready),
        .out_data  (acc_data)
    );

    ybc_clamp u_clamp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (acc_valid),
        .in_ready  (acc_ready),
        .in_data   (acc_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (pix_data)
    );

    assign m_tdata = {pix_data.red, pix_data.green, pix_data.blue};

    // beats in flight, for the checks below
    always_comb begin
        occ_next = occ_reg;
        if (s_tvalid && s_tready && !(m_tvalid && m_tready)) begin
            occ_next = occ_reg + 3'd1;
        end else if (!(s_tvalid && s_tready) && m_tvalid && m_tready) begin
            occ_next = occ_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    a_no_overfill: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= 3'd4)
        else $error("more beats in flight than pipeline stages");

    a_free_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output drains");

    a_out_has_source: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> occ_reg != 3'd0)
        else $error("output beat with nothing accepted");

    a_full_takes: assert property (@(posedge aclk) disable iff (!aresetn)
        (occ_reg == 3'd4 && !m_tready) |-> !s_tready)
        else $error("input taken while every stage is full");

endmodule

`default_nettype wire
